/* rtl/fastcgi_response_deframer_defines.svh */
// Assertion macros shared by the FastCGI response deframer modules.
`ifndef FASTCGI_RESPONSE_DEFRAMER_DEFINES_SVH
`define FASTCGI_RESPONSE_DEFRAMER_DEFINES_SVH

`ifndef SYNTH

// A property checked on every rising edge of clk while rst is low.
`define FCGI_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("fastcgi deframer assertion failed");

// The consequent must hold in the same cycle as the antecedent.
`define FCGI_ASSERT_IMPLY(label, ante, cons) \
  `FCGI_ASSERT(label, (ante) |-> (cons))

// The consequent must hold in the cycle after the antecedent.
`define FCGI_ASSERT_NEXT(label, ante, cons) \
  `FCGI_ASSERT(label, (ante) |=> (cons))

`else

`define FCGI_ASSERT(label, prop)
`define FCGI_ASSERT_IMPLY(label, ante, cons)
`define FCGI_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* rtl/fcgi_pkg.sv */
// Types and constants shared by the FastCGI response deframer modules.
package fcgi_pkg;

  // Record layout.
  localparam int HdrBytes     = 8;
  localparam int EndBodyBytes = 8;

  localparam logic [2:0] HDR_LAST  = 3'(HdrBytes - 1);
  localparam logic [2:0] END_LAST  = 3'(EndBodyBytes - 1);

  // Byte positions inside a record header.
  localparam logic [2:0] HDR_TYPE    = 3'd1;
  localparam logic [2:0] HDR_ID_HI   = 3'd2;
  localparam logic [2:0] HDR_ID_LO   = 3'd3;
  localparam logic [2:0] HDR_CLEN_HI = 3'd4;
  localparam logic [2:0] HDR_CLEN_LO = 3'd5;
  localparam logic [2:0] HDR_PAD     = 3'd6;

  // Byte positions inside an end-request body.
  localparam logic [2:0] END_STATUS_BYTES = 3'd4;
  localparam logic [2:0] END_PROTO_INDEX  = 3'd4;

  // Record types handled by the block.
  localparam logic [7:0] TYPE_END_REQUEST = 8'd3;
  localparam logic [7:0] TYPE_STDOUT      = 8'd6;
  localparam logic [7:0] TYPE_STDERR      = 8'd7;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_STDOUT      = 2'd0,
    KIND_STDERR      = 2'd1,
    KIND_ENDED       = 2'd2,
    KIND_UNSUPPORTED = 2'd3
  } kind_t;

  // Parser phases, one-hot.
  typedef enum logic [5:0] {
    PH_HEADER   = 6'b000001,
    PH_CONTENT  = 6'b000010,
    PH_PADDING  = 6'b000100,
    PH_END_BODY = 6'b001000,
    PH_ENDED    = 6'b010000,
    PH_HALTED   = 6'b100000
  } phase_t;

  // One result item.
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [15:0] req_id;
    logic [31:0] app_code;
    logic [7:0]  proto_code;
  } result_t;

endpackage

/* rtl/fcgi_parser.sv */
// Record parser: header collection, content, padding and end-body tracking.
`include "fastcgi_response_deframer_defines.svh"

module fcgi_parser import fcgi_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] byte_in,
  output logic       res_valid,
  output result_t    res
);

  phase_t      phase, phase_next;
  logic [2:0]  byte_index, byte_index_next;
  logic [7:0]  header_store [HdrBytes];
  logic [15:0] content_remaining, content_remaining_next;
  logic [7:0]  padding_remaining, padding_remaining_next;
  logic [7:0]  record_kind, record_kind_next;
  logic [31:0] status_shift, status_shift_next;
  logic        hdr_we;
  logic [15:0] hdr_clen;

  assign hdr_clen = {header_store[HDR_CLEN_HI], header_store[HDR_CLEN_LO]};

  // Next state and result for the byte now at the input register.
  always_comb begin
    phase_next             = phase;
    byte_index_next        = byte_index;
    content_remaining_next = content_remaining;
    padding_remaining_next = padding_remaining;
    record_kind_next       = record_kind;
    status_shift_next      = status_shift;
    hdr_we                 = 1'b0;
    res_valid              = 1'b0;
    res                    = '0;
    res.kind               = KIND_STDOUT;

    unique case (phase)
      PH_HEADER: begin
        hdr_we = 1'b1;
        if (byte_index != HDR_LAST) begin
          byte_index_next = byte_index + 3'd1;
        end else begin
          // The last header byte is not needed for decoding, so the stored
          // bytes are complete here.
          byte_index_next        = '0;
          record_kind_next       = header_store[HDR_TYPE];
          content_remaining_next = hdr_clen;
          padding_remaining_next = header_store[HDR_PAD];
          if (header_store[HDR_TYPE] == TYPE_END_REQUEST) begin
            status_shift_next = '0;
            phase_next        = PH_END_BODY;
          end else if (header_store[HDR_TYPE] == TYPE_STDOUT ||
                       header_store[HDR_TYPE] == TYPE_STDERR) begin
            if (hdr_clen != 16'd0) begin
              phase_next = PH_CONTENT;
            end else if (header_store[HDR_PAD] != 8'd0) begin
              phase_next = PH_PADDING;
            end else begin
              phase_next = PH_HEADER;
            end
          end else begin
            phase_next = PH_HALTED;
            res_valid  = 1'b1;
            res.kind   = KIND_UNSUPPORTED;
          end
        end
      end

      PH_CONTENT: begin
        res_valid              = 1'b1;
        res.kind               = (record_kind == TYPE_STDERR) ? KIND_STDERR : KIND_STDOUT;
        res.data_byte          = byte_in;
        content_remaining_next = content_remaining - 16'd1;
        if (content_remaining_next == 16'd0) begin
          phase_next = (padding_remaining != 8'd0) ? PH_PADDING : PH_HEADER;
        end
      end

      PH_PADDING: begin
        padding_remaining_next = padding_remaining - 8'd1;
        if (padding_remaining_next == 8'd0) begin
          phase_next = PH_HEADER;
        end
      end

      PH_END_BODY: begin
        // Status bytes shift in big-endian; the protocol status reuses a
        // header slot that the end result no longer needs.
        if (byte_index < END_STATUS_BYTES) begin
          status_shift_next = {status_shift[23:0], byte_in};
        end else if (byte_index == END_PROTO_INDEX) begin
          hdr_we = 1'b1;
        end
        if (byte_index != END_LAST) begin
          byte_index_next = byte_index + 3'd1;
        end else begin
          byte_index_next = '0;
          phase_next      = PH_ENDED;
          res_valid       = 1'b1;
          res.kind        = KIND_ENDED;
          res.req_id      = {header_store[HDR_ID_HI], header_store[HDR_ID_LO]};
          res.app_code    = status_shift;
          res.proto_code  = header_store[END_PROTO_INDEX];
        end
      end

      PH_ENDED, PH_HALTED: begin
        // All input is dropped until reset.
      end

      default: begin
        // Codes outside the phase set behave as halted.
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HEADER;
      byte_index        <= '0;
      content_remaining <= '0;
      padding_remaining <= '0;
      record_kind       <= '0;
      status_shift      <= '0;
    end else if (step) begin
      phase             <= phase_next;
      byte_index        <= byte_index_next;
      content_remaining <= content_remaining_next;
      padding_remaining <= padding_remaining_next;
      record_kind       <= record_kind_next;
      status_shift      <= status_shift_next;
    end
  end

  // Header bytes, written at the current byte position.
  always_ff @(posedge clk) begin
    if (step && hdr_we) begin
      header_store[byte_index] <= byte_in;
    end
  end

  `FCGI_ASSERT_IMPLY(a_content_nonzero, phase == PH_CONTENT, content_remaining != 16'd0)
  `FCGI_ASSERT_IMPLY(a_padding_nonzero, phase == PH_PADDING, padding_remaining != 8'd0)
  `FCGI_ASSERT_IMPLY(a_index_idle, phase != PH_HEADER && phase != PH_END_BODY, byte_index == 3'd0)
  `FCGI_ASSERT_NEXT(a_end_result_ends, step && res_valid && res.kind == KIND_ENDED, phase == PH_ENDED)
  `FCGI_ASSERT_NEXT(a_ended_sticks, phase == PH_ENDED, phase == PH_ENDED)

endmodule

/* rtl/fcgi_out_stage.sv */
// Output register holding one result item until it is taken.
module fcgi_out_stage import fcgi_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t load_res,
  output logic    can_load,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t res_q
);

  // A new item may enter when the register is empty or is being drained.
  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= load_res;
    end
  end

endmodule

/* rtl/fastcgi_response_deframer.sv */
// Top level of the FastCGI response deframer.
//
//  Channel  Handshake              Payload
//  -------  ---------------------  ---------------------------------------------
//  input    in_valid / in_ready    in_byte
//  output   out_valid / out_ready  kind, data_byte, req_id, app_code,
//                                  proto_code
//
// One byte per clock is sustained unless a stalled output holds a byte with a result;
// each byte is parsed combinationally between the input register and the output register.
// A result becomes valid once its byte has passed through the input register and
// has then been loaded into the output register.
// rst is synchronous and returns the parser to header collection.
// A stalled output holds only bytes that produce results; others keep flowing.
module fastcgi_response_deframer import fcgi_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [7:0]  data_byte,
  output logic [15:0] req_id,
  output logic [31:0] app_code,
  output logic [7:0]  proto_code
);

  logic       inq_valid;
  logic [7:0] inq_byte;
  logic       advance;
  logic       res_valid;
  result_t    res;
  logic       can_load;
  result_t    res_q;

  // The held item moves on unless it has a result and the output is full.
  assign advance  = inq_valid && (!res_valid || can_load);
  assign in_ready = !inq_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      inq_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      inq_valid <= 1'b1;
    end else if (advance) begin
      inq_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      inq_byte <= in_byte;
    end
  end

  fcgi_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .byte_in   (inq_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  fcgi_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && res_valid),
    .load_res  (res),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_q     (res_q)
  );

  assign kind       = res_q.kind;
  assign data_byte  = res_q.data_byte;
  assign req_id     = res_q.req_id;
  assign app_code   = res_q.app_code;
  assign proto_code = res_q.proto_code;

endmodule

/* dv/fastcgi_response_deframer_tb.sv */
// Self-checking testbench for the FastCGI response deframer, with its own byte-level predictor.
`timescale 1ns / 1ps

module fastcgi_response_deframer_tb;
  import fcgi_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_byte;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  kind;
  logic [7:0]  data_byte;
  logic [15:0] req_id;
  logic [31:0] app_code;
  logic [7:0]  proto_code;

  fastcgi_response_deframer dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .data_byte  (data_byte),
    .req_id     (req_id),
    .app_code   (app_code),
    .proto_code (proto_code)
  );

  // Parser state as the predictor sees it.
  phase_t      parse_phase;
  logic [2:0]  field_pos;
  logic [7:0]  hdr_bytes [8];
  logic [15:0] content_left;
  logic [7:0]  pad_left;
  logic [7:0]  rec_type;
  logic [31:0] status_acc;
  logic [7:0]  proto_hold;

  // Results the block still owes, oldest first.
  result_t     pending_results [$];
  result_t     want;

  int          mismatches = 0;
  int          bytes_sent = 0;
  bit          tx_idle_en = 1'b0;
  bit          rx_idle_en = 1'b0;
  int          rx_hold = 0;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog on the whole run.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("fastcgi_response_deframer verification failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] wanted);
    $display("mismatch at %0t: %s got %0h wanted %0h", $realtime, what, got, wanted);
    mismatches++;
  endtask

  // Predict the effect of one accepted byte on the parser.
  function automatic void deframe_byte(input logic [7:0] b);
    result_t r;
    r = '0;
    case (parse_phase)
      PH_HEADER: begin
        hdr_bytes[field_pos] = b;
        if (field_pos != HDR_LAST) begin
          field_pos = field_pos + 3'd1;
        end else begin
          field_pos    = '0;
          rec_type     = hdr_bytes[HDR_TYPE];
          content_left = {hdr_bytes[HDR_CLEN_HI], hdr_bytes[HDR_CLEN_LO]};
          pad_left     = hdr_bytes[HDR_PAD];
          if (rec_type == TYPE_END_REQUEST) begin
            status_acc  = '0;
            parse_phase = PH_END_BODY;
          end else if (rec_type == TYPE_STDOUT || rec_type == TYPE_STDERR) begin
            if (content_left != 0) parse_phase = PH_CONTENT;
            else if (pad_left != 0) parse_phase = PH_PADDING;
            else parse_phase = PH_HEADER;
          end else begin
            parse_phase = PH_HALTED;
            r.kind = KIND_UNSUPPORTED;
            pending_results.push_back(r);
          end
        end
      end
      PH_CONTENT: begin
        r.kind      = (rec_type == TYPE_STDERR) ? KIND_STDERR : KIND_STDOUT;
        r.data_byte = b;
        pending_results.push_back(r);
        content_left = content_left - 16'd1;
        if (content_left == 0) parse_phase = (pad_left != 0) ? PH_PADDING : PH_HEADER;
      end
      PH_PADDING: begin
        pad_left = pad_left - 8'd1;
        if (pad_left == 0) parse_phase = PH_HEADER;
      end
      PH_END_BODY: begin
        if (field_pos < END_STATUS_BYTES) status_acc = {status_acc[23:0], b};
        else if (field_pos == END_PROTO_INDEX) proto_hold = b;
        if (field_pos != END_LAST) begin
          field_pos = field_pos + 3'd1;
        end else begin
          field_pos    = '0;
          parse_phase  = PH_ENDED;
          r.kind       = KIND_ENDED;
          r.req_id     = {hdr_bytes[HDR_ID_HI], hdr_bytes[HDR_ID_LO]};
          r.app_code   = status_acc;
          r.proto_code = proto_hold;
          pending_results.push_back(r);
        end
      end
      default: ;
    endcase
  endfunction

  // Offer one item, with an optional idle burst first, and predict it once accepted.
  task automatic push_byte(input logic [7:0] b);
    int gap;
    if (tx_idle_en && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 19);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    deframe_byte(b);
  endtask

  task automatic send_header(input logic [7:0] ver, input logic [7:0] rtype,
                             input logic [15:0] id, input logic [15:0] len,
                             input logic [7:0] pad);
    push_byte(ver);
    push_byte(rtype);
    push_byte(id[15:8]);
    push_byte(id[7:0]);
    push_byte(len[15:8]);
    push_byte(len[7:0]);
    push_byte(pad);
    push_byte(8'($urandom));
  endtask

  // A stdout or stderr record with random content and padding bytes.
  task automatic send_data_record(input logic [7:0] rtype, input logic [15:0] len,
                                  input logic [7:0] pad);
    send_header(8'($urandom), rtype, 16'($urandom), len, pad);
    for (int i = 0; i < len; i++) push_byte(8'($urandom));
    for (int i = 0; i < pad; i++) push_byte(8'($urandom));
  endtask

  // Stop offering and wait until every owed result has come out.
  task automatic drain_results;
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Extreme bytes, an empty record with an odd version, padding and both streams.
  task automatic test_directed;
    send_header(8'hFF, TYPE_STDOUT, 16'hFFFF, 16'd0, 8'd0);
    send_header(8'h00, TYPE_STDOUT, 16'h0000, 16'd2, 8'd1);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'hA5);
    send_header(8'h01, TYPE_STDERR, 16'h1234, 16'd1, 8'd0);
    push_byte(8'h5A);
  endtask

  // Random well-formed data records; mostly short, a few long ones.
  task automatic test_random_records;
    int          stop_at;
    int          pick;
    logic [7:0]  rtype;
    logic [15:0] len;
    logic [7:0]  pad;
    stop_at = bytes_sent + 1150;
    while (bytes_sent < stop_at) begin
      tx_idle_en = ($urandom_range(0, 3) != 0);
      rx_idle_en = ($urandom_range(0, 3) != 0);
      rtype = $urandom_range(0, 1) ? TYPE_STDERR : TYPE_STDOUT;
      pick = $urandom_range(0, 99);
      if (pick < 85) len = 16'($urandom_range(0, 10));
      else if (pick < 96) len = 16'($urandom_range(11, 80));
      else len = 16'($urandom_range(256, 520));
      pick = $urandom_range(0, 99);
      if (pick < 65) pad = 8'd0;
      else if (pick < 95) pad = 8'($urandom_range(1, 7));
      else pad = 8'($urandom_range(200, 255));
      send_data_record(rtype, len, pad);
    end
  endtask

  // Receiver holds off long enough for the block to fill and stall its input.
  task automatic test_backpressure;
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    rx_hold = 300;
    send_data_record(TYPE_STDOUT, 16'd48, 8'd0);
    send_data_record(TYPE_STDERR, 16'd16, 8'd3);
  endtask

  // Sender pauses until the block is empty, then resumes.
  task automatic test_pause_and_resume;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    drain_results();
    send_data_record(TYPE_STDERR, 16'd5, 8'd2);
    send_data_record(TYPE_STDOUT, 16'd0, 8'd4);
  endtask

  // One terminal record, an end request or an unsupported type, then ignored bytes.
  task automatic test_terminal_record;
    logic [7:0] rtype;
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    if ($urandom_range(0, 1) == 0) begin
      send_header(8'($urandom), TYPE_END_REQUEST, 16'($urandom), 16'($urandom),
                  8'($urandom));
      for (int i = 0; i < 8; i++) push_byte(8'($urandom));
    end else begin
      do rtype = 8'($urandom);
      while (rtype == TYPE_END_REQUEST || rtype == TYPE_STDOUT || rtype == TYPE_STDERR);
      send_header(8'($urandom), rtype, 16'($urandom), 16'($urandom), 8'($urandom));
    end
    for (int i = 0; i < 16; i++) push_byte(8'($urandom));
  endtask

  // Receiver side: random stall bursts and the long hold-off.
  initial begin : rx_side
    int   burst;
    logic ready_next;
    burst = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        rx_hold--;
        ready_next = 1'b0;
      end else if (burst > 0) begin
        burst--;
        ready_next = 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 19) - 1;
        ready_next = 1'b0;
      end else begin
        ready_next = 1'b1;
      end
      out_ready <= ready_next;
    end
  end

  // Compare every accepted result with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, kind", 32'(kind), 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (kind != want.kind) report_mismatch("kind", 32'(kind), 32'(want.kind));
        if (data_byte != want.data_byte)
          report_mismatch("data_byte", 32'(data_byte), 32'(want.data_byte));
        if (req_id != want.req_id)
          report_mismatch("req_id", 32'(req_id), 32'(want.req_id));
        if (app_code != want.app_code)
          report_mismatch("app_code", app_code, want.app_code);
        if (proto_code != want.proto_code)
          report_mismatch("proto_code", 32'(proto_code), 32'(want.proto_code));
      end
    end
  end

  // Main sequence.
  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    in_byte      = 8'h00;
    parse_phase  = PH_HEADER;
    field_pos    = '0;
    content_left = '0;
    pad_left     = '0;
    rec_type     = '0;
    status_acc   = '0;
    proto_hold   = '0;
    for (int i = 0; i < 8; i++) hdr_bytes[i] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_records();
    test_backpressure();
    test_pause_and_resume();
    test_terminal_record();

    drain_results();
    if (mismatches == 0) begin
      $display("fastcgi_response_deframer verification clean");
    end else begin
      $display("fastcgi_response_deframer verification failed");
    end
    $finish;
  end

endmodule
